// ----- rtl/b64_pkg.sv -----
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and alphabet functions of the Base64 stream codec.
// ----------------------------------------------------------------------------
package b64_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } t_dir;

    // one queued entry: up to four output words
    typedef struct packed {
        logic [1:0]      last_idx;
        logic [3:0][7:0] chars;
        logic            dvalid;
        logic            eom;
    } t_cmd;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        c = 8'h00;
        if (v < 6'd26) begin
            c = 8'({2'b00, v}) + 8'd65;
        end else if (v < 6'd52) begin
            c = 8'({2'b00, v}) + 8'd71;
        end else if (v < 6'd62) begin
            c = 8'({2'b00, v}) - 8'd4;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    function automatic logic [5:0] dec_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h41 && c <= 8'h5A) begin
            t = c - 8'd65;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            t = c - 8'd71;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            t = c + 8'd4;
        end else if (c == 8'h2B) begin
            t = 8'd62;
        end else if (c == 8'h2F) begin
            t = 8'd63;
        end
        return t[5:0];
    endfunction

endpackage

// ----- rtl/b64_front.sv -----
// ----------------------------------------------------------------------------
// b64_front
// Accepts input words, tracks group phase and carry, builds queue entries.
// ----------------------------------------------------------------------------
module b64_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_data,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_data_in,
    input  logic          i_end_in,
    input  logic          i_q_full,
    output logic          o_push,
    output b64_pkg::t_cmd o_cmd
);
    import b64_pkg::*;

    t_dir       r_dir;
    logic [1:0] r_phase, n_phase;
    logic [5:0] r_carry, n_carry;
    logic       has_word;
    logic       accept;
    t_cmd       cmd;
    logic       pad;
    logic [5:0] dv;
    logic [1:0] eph;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign pad     = (i_data_in == PAD_CHAR);
    assign dv      = pad ? 6'd0 : dec_value(i_data_in);
    assign eph     = (r_phase == 2'd3) ? 2'd0 : r_phase;

    always_comb begin
        cmd      = '0;
        n_phase  = r_phase;
        n_carry  = r_carry;
        has_word = 1'b1;
        cmd.dvalid = 1'b1;
        cmd.eom    = i_end_in;
        if (r_dir == DIR_ENCODE) begin
            case (eph)
                2'd0: begin
                    cmd.chars[0] = enc_char(i_data_in[7:2]);
                    n_carry = {i_data_in[1:0], 4'b0000};
                    n_phase = 2'd1;
                    if (i_end_in) begin
                        cmd.chars[1] = enc_char(n_carry);
                        cmd.chars[2] = PAD_CHAR;
                        cmd.chars[3] = PAD_CHAR;
                        cmd.last_idx = 2'd3;
                    end
                end
                2'd1: begin
                    cmd.chars[0] = enc_char(r_carry | {2'b00, i_data_in[7:4]});
                    n_carry = {i_data_in[3:0], 2'b00};
                    n_phase = 2'd2;
                    if (i_end_in) begin
                        cmd.chars[1] = enc_char(n_carry);
                        cmd.chars[2] = PAD_CHAR;
                        cmd.last_idx = 2'd2;
                    end
                end
                default: begin
                    cmd.chars[0] = enc_char(r_carry | {4'b0000, i_data_in[7:6]});
                    cmd.chars[1] = enc_char(i_data_in[5:0]);
                    cmd.last_idx = 2'd1;
                    n_carry = 6'd0;
                    n_phase = 2'd0;
                end
            endcase
        end else begin
            n_phase = r_phase + 2'd1;
            has_word = !pad;
            case (r_phase)
                2'd0: begin
                    n_carry  = dv;
                    has_word = 1'b0;
                end
                2'd1: begin
                    cmd.chars[0] = {r_carry, dv[5:4]};
                    n_carry = {2'b00, dv[3:0]};
                end
                2'd2: begin
                    cmd.chars[0] = {r_carry[3:0], dv[5:2]};
                    n_carry = {4'b0000, dv[1:0]};
                end
                default: begin
                    cmd.chars[0] = {r_carry[1:0], dv};
                    n_carry = 6'd0;
                end
            endcase
            if (!has_word) begin
                cmd.chars[0] = 8'h00;
                cmd.dvalid   = 1'b0;
            end
        end
        if (i_end_in) begin
            n_phase = 2'd0;
            n_carry = 6'd0;
        end
    end

    assign o_push = accept && (has_word || i_end_in);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= DIR_ENCODE;
            r_phase <= 2'd0;
            r_carry <= 6'd0;
        end else if (i_cfg_we) begin
            r_dir   <= t_dir'(i_cfg_data);
            r_phase <= 2'd0;
            r_carry <= 6'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

endmodule

// ----- rtl/b64_queue.sv -----
// ----------------------------------------------------------------------------
// b64_queue
// Short entry queue between the front and the back.
// ----------------------------------------------------------------------------
module b64_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  b64_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output b64_pkg::t_cmd o_head
);
    import b64_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, r_rptr;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/b64_back.sv -----
// ----------------------------------------------------------------------------
// b64_back
// Walks each queue entry word by word into the output register.
// ----------------------------------------------------------------------------
module b64_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  b64_pkg::t_cmd i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_data_out,
    output logic          o_data_valid,
    output logic          o_end_out
);
    import b64_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_dvalid;
    logic       r_end;
    logic [1:0] r_idx;
    logic       load;
    logic       last;

    assign load  = !i_empty && (!r_valid || !i_stall);
    assign last  = (r_idx == i_head.last_idx);
    assign o_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data   <= i_head.chars[r_idx];
            r_dvalid <= i_head.dvalid;
            r_end    <= i_head.eom && last;
        end
    end

    assign o_valid      = r_valid;
    assign o_data_out   = r_data;
    assign o_data_valid = r_dvalid;
    assign o_end_out    = r_end;

endmodule

// ----- rtl/base64_stream_codec.sv -----
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming Base64 codec, standard alphabet, one byte per input word.
// ----------------------------------------------------------------------------
// The direction register (0 encode, 1 decode) is written with i_cfg_we and
// clears the group state. Each accepted input word becomes up to four output
// words, held as one entry of a four-entry queue; the output side drains one
// word per cycle unless stalled, so the output port sets the rate: decoding
// keeps one input word per cycle unless stalled, encoding gives four output
// words per three input bytes, plus the pad words at end of message. End of
// message is marked by i_end_in; a decode end that yields no byte gives one
// empty word with o_data_valid low and o_end_out high.
module base64_stream_codec (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_in,
    input  logic       i_end_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_data_out,
    output logic       o_data_valid,
    output logic       o_end_out
);
    import b64_pkg::*;

    logic q_full, q_empty, push, pop;
    t_cmd cmd, head;

    b64_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data_in  (i_data_in),
        .i_end_in   (i_end_in),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    b64_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head)
    );

    b64_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data_out   (o_data_out),
        .o_data_valid (o_data_valid),
        .o_end_out    (o_end_out)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Base64 stream codec. Bytes and characters are
// pushed through the input channel in both directions; a scoreboard class
// predicts each output word from its own copy of the group state and checks
// every word leaving the block, in order, field by field. Both channels idle
// at random, and one long output hold-off makes the block back up its input.
// ----------------------------------------------------------------------------
module testbench;
    import b64_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       dvalid;
        logic       eom;
    } t_b64_word;

    class b64_scoreboard;
        t_dir       dir;
        logic [1:0] phase;
        logic [5:0] carry;
        t_b64_word  expected_words[$];
        int         errors;
        int         checked;

        function new();
            dir     = DIR_ENCODE;
            phase   = 2'd0;
            carry   = 6'd0;
            errors  = 0;
            checked = 0;
        endfunction

        function logic [7:0] sextet_char(input logic [5:0] v);
            logic [511:0] alphabet_bits;
            int           idx;
            alphabet_bits =
                "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            idx = 63 - int'(v);
            return alphabet_bits[8*idx +: 8];
        endfunction

        function logic [5:0] char_value(input logic [7:0] c);
            logic [5:0] v;
            v = 6'd0;
            for (int k = 0; k < 64; k++) begin
                if (sextet_char(6'(k)) == c) begin
                    v = 6'(k);
                end
            end
            return v;
        endfunction

        function void set_direction(input t_dir d);
            dir   = d;
            phase = 2'd0;
            carry = 6'd0;
        endfunction

        function void expect_word(input logic [7:0] d, input logic dv);
            t_b64_word w;
            w.data   = d;
            w.dvalid = dv;
            w.eom    = 1'b0;
            expected_words.push_back(w);
        endfunction

        function void note_input(input logic [7:0] d, input logic e);
            logic [1:0] ph;
            logic [5:0] v;
            logic [7:0] byte_v;
            logic       pad;
            logic       have;
            int         n_before;
            t_b64_word  w;
            n_before = expected_words.size();
            if (dir == DIR_ENCODE) begin
                ph = (phase == 2'd3) ? 2'd0 : phase;
                case (ph)
                    2'd0: begin
                        expect_word(sextet_char(d[7:2]), 1'b1);
                        carry = {d[1:0], 4'b0000};
                        phase = 2'd1;
                    end
                    2'd1: begin
                        expect_word(sextet_char({carry[5:4], d[7:4]}), 1'b1);
                        carry = {d[3:0], 2'b00};
                        phase = 2'd2;
                    end
                    default: begin
                        expect_word(sextet_char({carry[5:2], d[7:6]}), 1'b1);
                        expect_word(sextet_char(d[5:0]), 1'b1);
                        carry = 6'd0;
                        phase = 2'd0;
                    end
                endcase
                if (e) begin
                    if (phase == 2'd1) begin
                        expect_word(sextet_char(carry), 1'b1);
                        expect_word(PAD_CHAR, 1'b1);
                        expect_word(PAD_CHAR, 1'b1);
                    end else if (phase == 2'd2) begin
                        expect_word(sextet_char(carry), 1'b1);
                        expect_word(PAD_CHAR, 1'b1);
                    end
                end
            end else begin
                pad    = (d == PAD_CHAR);
                v      = pad ? 6'd0 : char_value(d);
                byte_v = 8'd0;
                have   = 1'b0;
                case (phase)
                    2'd0: begin
                        carry = v;
                    end
                    2'd1: begin
                        byte_v = {carry, v[5:4]};
                        carry  = {2'b00, v[3:0]};
                        have   = 1'b1;
                    end
                    2'd2: begin
                        byte_v = {carry[3:0], v[5:2]};
                        carry  = {4'b0000, v[1:0]};
                        have   = 1'b1;
                    end
                    default: begin
                        byte_v = {carry[1:0], v};
                        carry  = 6'd0;
                        have   = 1'b1;
                    end
                endcase
                phase = phase + 2'd1;
                if (have && !pad) begin
                    expect_word(byte_v, 1'b1);
                end
                if (e && expected_words.size() == n_before) begin
                    expect_word(8'd0, 1'b0);
                end
            end
            if (e) begin
                w = expected_words.pop_back();
                w.eom = 1'b1;
                expected_words.push_back(w);
                phase = 2'd0;
                carry = 6'd0;
            end
        endfunction

        function void check_result(input logic [7:0] d, input logic dv, input logic eom);
            t_b64_word w;
            checked++;
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t unexpected word: data %h dvalid %b end %b", $time, d, dv, eom);
                return;
            end
            w = expected_words.pop_front();
            if (w.data !== d) begin
                errors++;
                $display("%0t data mismatch: expected %h actual %h", $time, w.data, d);
            end
            if (w.dvalid !== dv) begin
                errors++;
                $display("%0t data_valid mismatch: expected %b actual %b",
                         $time, w.dvalid, dv);
            end
            if (w.eom !== eom) begin
                errors++;
                $display("%0t end_out mismatch: expected %b actual %b", $time, w.eom, eom);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_data;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_data_in;
    logic       i_end_in;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_data_out;
    logic       o_data_valid;
    logic       o_end_out;

    b64_scoreboard sb;
    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;
    int            hold_left   = 0;
    int            words_sent  = 0;

    base64_stream_codec DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_in    (i_data_in),
        .i_end_in     (i_end_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data_out   (o_data_out),
        .o_data_valid (o_data_valid),
        .o_end_out    (o_end_out)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_input(i_data_in, i_end_in);
            end
            if (o_valid && !i_stall) begin
                sb.check_result(o_data_out, o_data_valid, o_end_out);
            end
        end
    end

    // output side: random stall, or a long hold-off when requested
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d words still expected", sb.expected_words.size());
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_word(input logic [7:0] d, input logic e);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_data_in <= d;
        i_end_in  <= e;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        words_sent++;
    endtask

    // drop valid and wait until every expected word has come out
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_direction(input t_dir d);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_direction(d);
    endtask

    task automatic send_bytes(input int n_items);
        int start;
        int len;
        start = words_sent;
        while (words_sent - start < n_items) begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++) begin
                send_word(8'($urandom_range(0, 255)), i == len - 1);
            end
        end
    endtask

    task automatic send_text(input int n_items);
        int         start;
        int         groups;
        int         pads;
        int         len;
        int         r;
        logic [7:0] c;
        start = words_sent;
        while (words_sent - start < n_items) begin
            if ($urandom_range(99) < 75) begin
                // well-formed text, with up to two pad characters at the end
                groups = $urandom_range(1, 3);
                pads   = $urandom_range(0, 2);
                for (int g = 0; g < groups; g++) begin
                    for (int k = 0; k < 4; k++) begin
                        if (g == groups - 1 && k >= 4 - pads) begin
                            c = PAD_CHAR;
                        end else begin
                            c = sb.sextet_char(6'($urandom_range(0, 63)));
                        end
                        send_word(c, g == groups - 1 && k == 3);
                    end
                end
            end else begin
                len = $urandom_range(1, 7);
                for (int i = 0; i < len; i++) begin
                    r = $urandom_range(99);
                    if (r < 40) begin
                        c = sb.sextet_char(6'($urandom_range(0, 63)));
                    end else if (r < 60) begin
                        c = PAD_CHAR;
                    end else begin
                        c = 8'($urandom_range(0, 255));
                    end
                    send_word(c, i == len - 1);
                end
            end
        end
    endtask

    task automatic run_phase(input int tx, input int rx, input int n_items, input bit hold);
        tx_idle_pct = tx;
        rx_idle_pct = rx;
        write_direction(DIR_ENCODE);
        if (hold) begin
            hold_left = 150;
        end
        send_bytes(n_items);
        settle();
        write_direction(DIR_DECODE);
        send_text(n_items);
        settle();
    endtask

    initial begin
        sb         = new();
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = 1'b0;
        i_valid    = 1'b0;
        i_data_in  = 8'd0;
        i_end_in   = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // encode: one byte left, two bytes left, write mid-group, full group
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h80, 1'b0);
        settle();
        write_direction(DIR_ENCODE);
        send_word(8'h4D, 1'b0);
        send_word(8'h61, 1'b0);
        send_word(8'h6E, 1'b1);
        settle();

        // decode: pads, lone pad, bad characters, empty end words
        write_direction(DIR_DECODE);
        send_word("T", 1'b0);
        send_word("Q", 1'b0);
        send_word(PAD_CHAR, 1'b0);
        send_word(PAD_CHAR, 1'b1);
        send_word(PAD_CHAR, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word("!", 1'b0);
        send_word("z", 1'b1);
        send_word("Q", 1'b1);
        send_word("B", 1'b0);
        send_word(PAD_CHAR, 1'b1);
        send_word("+", 1'b0);
        send_word("/", 1'b0);
        send_word("9", 1'b0);
        settle();
        write_direction(DIR_DECODE);
        send_word("0", 1'b1);
        settle();

        run_phase(7, 47, 40, 1'b0);
        run_phase(47, 7, 40, 1'b0);
        run_phase(0, 0, 30, 1'b1);

        $display("covered %0d input words over encode and decode, %0d output words checked",
                 words_sent, sb.checked);
        $display("mixed idling on both sides and one long output hold-off were exercised");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
